[src/hsvr_pkg.sv]
// Shared constants and types for the HSV to RGB converter pipeline.
package hsvr_pkg;

    localparam int HUE_W    = 10;
    localparam int HUE_MOD_W = 9;
    localparam int CH_W     = 8;
    localparam int WEIGHT_W = 6;
    localparam int INNER_W  = 14;
    localparam int NUM_W    = 22;
    localparam int RECIP_W  = 19;
    localparam int PROD_W   = NUM_W + RECIP_W;
    localparam int SHIFT    = 32;
    localparam int NUM_CH   = 3;
    localparam int STAGES   = 5;

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    localparam logic [HUE_W-1:0]     FULL_TURN    = 10'd360;
    localparam logic [HUE_W-1:0]     DOUBLE_TURN  = 10'd720;
    localparam logic [WEIGHT_W-1:0]  SECTOR_DEG   = 6'd60;
    localparam logic [CH_W-1:0]      FULL_SCALE   = 8'd255;
    localparam logic [INNER_W-1:0]   DIVISOR      = 14'd15300;
    // floor(2^32 / 15300); the estimate it gives is low by at most one.
    localparam logic [RECIP_W-1:0]   RECIP        = 19'd280716;

    typedef logic [CH_W-1:0]     chan_t;
    typedef logic [WEIGHT_W-1:0] weight_t;
    typedef logic [INNER_W-1:0]  inner_t;
    typedef logic [NUM_W-1:0]    num_t;

endpackage

[src/hsvr_sector.sv]
// First pipeline stage: hue reduction, sector decode and per-channel weights.
module hsvr_sector
    import hsvr_pkg::*;
(
    input  logic                         clk,
    input  logic                         load,
    input  logic [HUE_W-1:0]             hue_degrees,
    input  chan_t                        saturation,
    input  chan_t                        brightness,
    output weight_t [NUM_CH-1:0]         weights,
    output chan_t                        sat,
    output chan_t                        val
);

    typedef enum logic [2:0] {
        SEC_RED_YELLOW,
        SEC_YELLOW_GREEN,
        SEC_GREEN_CYAN,
        SEC_CYAN_BLUE,
        SEC_BLUE_MAGENTA,
        SEC_MAGENTA_RED
    } sector_t;

    logic [HUE_MOD_W-1:0] hue_mod;
    logic [HUE_MOD_W-1:0] base;
    sector_t              sector;
    weight_t              offset;
    weight_t              d;
    weight_t [NUM_CH-1:0] weights_next;
    weight_t [NUM_CH-1:0] weights_reg;
    chan_t                sat_reg;
    chan_t                val_reg;

    always_comb
    begin
        priority if (hue_degrees >= DOUBLE_TURN)
            hue_mod = HUE_MOD_W'(hue_degrees - DOUBLE_TURN);
        else if (hue_degrees >= FULL_TURN)
            hue_mod = HUE_MOD_W'(hue_degrees - FULL_TURN);
        else
            hue_mod = HUE_MOD_W'(hue_degrees);

        priority if (hue_mod < 9'd60)
        begin
            sector = SEC_RED_YELLOW;   base = 9'd0;
        end
        else if (hue_mod < 9'd120)
        begin
            sector = SEC_YELLOW_GREEN; base = 9'd60;
        end
        else if (hue_mod < 9'd180)
        begin
            sector = SEC_GREEN_CYAN;   base = 9'd120;
        end
        else if (hue_mod < 9'd240)
        begin
            sector = SEC_CYAN_BLUE;    base = 9'd180;
        end
        else if (hue_mod < 9'd300)
        begin
            sector = SEC_BLUE_MAGENTA; base = 9'd240;
        end
        else
        begin
            sector = SEC_MAGENTA_RED;  base = 9'd300;
        end

        offset = WEIGHT_W'(hue_mod - base);
        // The secondary weight rises through even sectors and falls through odd ones.
        d = sector[0] ? (SECTOR_DEG - offset) : offset;

        unique case (sector)
            SEC_RED_YELLOW:
            begin
                weights_next[CH_RED] = SECTOR_DEG; weights_next[CH_GREEN] = d;
                weights_next[CH_BLUE] = '0;
            end
            SEC_YELLOW_GREEN:
            begin
                weights_next[CH_RED] = d; weights_next[CH_GREEN] = SECTOR_DEG;
                weights_next[CH_BLUE] = '0;
            end
            SEC_GREEN_CYAN:
            begin
                weights_next[CH_RED] = '0; weights_next[CH_GREEN] = SECTOR_DEG;
                weights_next[CH_BLUE] = d;
            end
            SEC_CYAN_BLUE:
            begin
                weights_next[CH_RED] = '0; weights_next[CH_GREEN] = d;
                weights_next[CH_BLUE] = SECTOR_DEG;
            end
            SEC_BLUE_MAGENTA:
            begin
                weights_next[CH_RED] = d; weights_next[CH_GREEN] = '0;
                weights_next[CH_BLUE] = SECTOR_DEG;
            end
            SEC_MAGENTA_RED:
            begin
                weights_next[CH_RED] = SECTOR_DEG; weights_next[CH_GREEN] = '0;
                weights_next[CH_BLUE] = d;
            end
            default:
            begin
                weights_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            weights_reg <= weights_next;
            sat_reg     <= saturation;
            val_reg     <= brightness;
        end
    end

    assign weights = weights_reg;
    assign sat     = sat_reg;
    assign val     = val_reg;

endmodule

[src/hsvr_level.sv]
// Stages two and three of one channel: weighted saturation term, then scale by value.
module hsvr_level
    import hsvr_pkg::*;
(
    input  logic       clk,
    input  logic [1:0] load,
    input  weight_t    weight,
    input  chan_t      sat,
    input  chan_t      val,
    output num_t       num
);

    inner_t inner_next;
    inner_t inner_reg;
    chan_t  val_reg;
    num_t   num_next;
    num_t   num_reg;

    always_comb
    begin
        // sat*w + 60*(255 - sat) never exceeds 15300.
        inner_next = INNER_W'(INNER_W'(sat) * INNER_W'(weight))
                   + INNER_W'(INNER_W'(FULL_SCALE - sat) * INNER_W'(SECTOR_DEG));
        num_next   = NUM_W'(val_reg) * NUM_W'(inner_reg);
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            inner_reg <= inner_next;
            val_reg   <= val;
        end
        if (load[1])
        begin
            num_reg <= num_next;
        end
    end

    assign num = num_reg;

endmodule

[src/hsvr_divide.sv]
// Stages four and five of one channel: exact division by 15300 via reciprocal and correction.
module hsvr_divide
    import hsvr_pkg::*;
(
    input  logic       clk,
    input  logic [1:0] load,
    input  num_t       num,
    output chan_t      level
);

    logic [PROD_W-1:0] prod;
    chan_t             q0_next;
    chan_t             q0_reg;
    num_t              num_reg;
    num_t              qd;
    num_t              rem;
    chan_t             level_next;
    chan_t             level_reg;

    always_comb
    begin
        prod       = PROD_W'(num) * PROD_W'(RECIP);
        // The quotient is at most 255, so the estimate fits in a channel.
        q0_next    = prod[SHIFT+CH_W-1:SHIFT];
        qd         = NUM_W'(q0_reg) * NUM_W'(DIVISOR);
        rem        = num_reg - qd;
        level_next = (rem >= NUM_W'(DIVISOR)) ? (q0_reg + 8'd1) : q0_reg;
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            q0_reg  <= q0_next;
            num_reg <= num;
        end
        if (load[1])
        begin
            level_reg <= level_next;
        end
    end

    assign level = level_reg;

endmodule

[src/hsv_to_rgb_converter.sv]
// Top level of the HSV to RGB converter: five-stage pipeline with per-stage valid bits.
// An accepted item moves through the sector, level and divide stages in order.
// Throughput: one item per cycle while the output is not stalled; the reciprocal
// multiply in stage four is the widest path.
// Reset: rst_n clears every stage valid bit asynchronously; data registers are not reset.
// A stall on the output holds full stages in place and lets bubbles upstream close up.
module hsv_to_rgb_converter
    import hsvr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [HUE_W-1:0] hue_degrees,
    input  chan_t            saturation,
    input  chan_t            brightness,
    output logic             out_valid,
    input  logic             out_stall,
    output chan_t            red,
    output chan_t            green,
    output chan_t            blue
);

    // One valid bit per pipeline stage; a stage moves when it is empty or the
    // stage after it moves, so a full stage is never overwritten.
    logic [STAGES-1:0]    valid_reg;
    logic [STAGES-1:0]    valid_next;
    logic [STAGES-1:0]    adv;

    weight_t [NUM_CH-1:0] weights;
    chan_t                sat;
    chan_t                val;
    num_t  [NUM_CH-1:0]   num;
    chan_t [NUM_CH-1:0]   level;

    always_comb
    begin
        adv[STAGES-1] = !valid_reg[STAGES-1] || !out_stall;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
        if (adv[0])
            valid_next[0] = in_valid;
        else
            valid_next[0] = valid_reg[0];
        for (int i = 1; i < STAGES; i++)
        begin
            if (adv[i])
                valid_next[i] = valid_reg[i-1];
            else
                valid_next[i] = valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign in_stall  = !adv[0];
    assign out_valid = valid_reg[STAGES-1];

    // Stage one: hue reduction and sector weights, shared by all channels.
    hsvr_sector u_sector (
        .clk         (clk),
        .load        (adv[0]),
        .hue_degrees (hue_degrees),
        .saturation  (saturation),
        .brightness  (brightness),
        .weights     (weights),
        .sat         (sat),
        .val         (val)
    );

    // Stages two through five run as three identical lanes, one per channel.
    for (genvar c = 0; c < NUM_CH; c++)
    begin : g_lane
        hsvr_level u_level (
            .clk    (clk),
            .load   (adv[2:1]),
            .weight (weights[c]),
            .sat    (sat),
            .val    (val),
            .num    (num[c])
        );

        hsvr_divide u_divide (
            .clk   (clk),
            .load  (adv[4:3]),
            .num   (num[c]),
            .level (level[c])
        );
    end

    assign red   = level[CH_RED];
    assign green = level[CH_GREEN];
    assign blue  = level[CH_BLUE];

    // Input is held back only when every stage is occupied.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (&valid_reg))
        else $error("input stalled while a pipeline stage was empty");

    // An accepted item always lands in the first stage.
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> valid_reg[0])
        else $error("accepted item lost at pipeline entry");

    // An item leaving stage four always reaches the output stage.
    a_last_move: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[STAGES-2] && adv[STAGES-2]) |=> valid_reg[STAGES-1])
        else $error("item lost between last two stages");

    // A held output item is not dropped while the consumer stalls.
    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(level)))
        else $error("stalled output item changed or vanished");

endmodule

[bench/hsv_to_rgb_converter_test.sv]
// Self-checking testbench for the HSV to RGB pixel converter.
module hsv_to_rgb_converter_test;
    import hsvr_pkg::*;

    // Arithmetic constants of the conversion, kept local so that the
    // prediction does not lean on the design's own package values.
    localparam int unsigned TURN_DEG    = 360;
    localparam int unsigned SECTOR_SPAN = 60;
    localparam int unsigned LEVEL_MAX   = 255;
    localparam int unsigned LEVEL_DIV   = 15300;

    localparam int RANDOM_PIXELS = 600;
    // Cycles after the last result before the run ends; the pipeline is five deep.
    localparam int DRAIN_CYCLES  = 12;
    // Cycles with no handshake on either side before the run is declared hung.
    // The longest legal quiet stretch is a sender gap plus a run of stalls, far below this.
    localparam int HANG_LIMIT    = 2000;

    // Six 60-degree hue sectors, in the order the hue angle walks through them.
    typedef enum int {
        SECT_RED_YELLOW,
        SECT_YELLOW_GREEN,
        SECT_GREEN_CYAN,
        SECT_CYAN_BLUE,
        SECT_BLUE_MAGENTA,
        SECT_MAGENTA_RED
    } hue_sector_e;

    // Receiver behaviors; one is picked for each window of cycles.
    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_EVERY_THIRD
    } stall_mode_e;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
    } rgb_pixel_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic [HUE_W-1:0] hue_degrees;
    chan_t            saturation;
    chan_t            brightness;
    logic             out_valid;
    logic             out_stall = 1'b0;
    chan_t            red;
    chan_t            green;
    chan_t            blue;

    // Pixels still owed by the converter, oldest first.
    rgb_pixel_t  expected_pixels[$];
    int          mismatch_count = 0;
    int          quiet_cycles = 0;
    stall_mode_e stall_mode = STALL_NONE;
    int          stall_window = 0;
    int          stall_phase = 0;

    hsv_to_rgb_converter dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .hue_degrees (hue_degrees),
        .saturation  (saturation),
        .brightness  (brightness),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .red         (red),
        .green       (green),
        .blue        (blue)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // One channel level: the weight is 60 for the chroma, d for the secondary
    // component and 0 for the empty channel. The product stays exact in 32 bits.
    function automatic chan_t channel_level(input int unsigned sat, input int unsigned val,
                                            input int unsigned weight);
        int unsigned scaled;
        scaled = val * (sat * weight + SECTOR_SPAN * (LEVEL_MAX - sat));
        return chan_t'(scaled / LEVEL_DIV);
    endfunction

    // Expected color of one pixel. Hue wraps at a full turn for any 10-bit value.
    function automatic rgb_pixel_t rgb_from_hsv(input logic [HUE_W-1:0] hue, input chan_t sat,
                                                input chan_t val);
        int unsigned angle;
        int unsigned offset;
        int unsigned secondary;
        int unsigned w_red;
        int unsigned w_green;
        int unsigned w_blue;
        hue_sector_e sector;
        rgb_pixel_t  pixel;
        angle  = int'(hue) % TURN_DEG;
        offset = angle % (2 * SECTOR_SPAN);
        // Secondary weight rises from 0 to 60 and back across each pair of sectors.
        secondary = (offset >= SECTOR_SPAN) ? (2 * SECTOR_SPAN - offset) : offset;
        sector = hue_sector_e'(angle / SECTOR_SPAN);
        case (sector)
            SECT_RED_YELLOW:   begin w_red = SECTOR_SPAN; w_green = secondary; w_blue = 0; end
            SECT_YELLOW_GREEN: begin w_red = secondary; w_green = SECTOR_SPAN; w_blue = 0; end
            SECT_GREEN_CYAN:   begin w_red = 0; w_green = SECTOR_SPAN; w_blue = secondary; end
            SECT_CYAN_BLUE:    begin w_red = 0; w_green = secondary; w_blue = SECTOR_SPAN; end
            SECT_BLUE_MAGENTA: begin w_red = secondary; w_green = 0; w_blue = SECTOR_SPAN; end
            default:           begin w_red = SECTOR_SPAN; w_green = 0; w_blue = secondary; end
        endcase
        pixel.red   = channel_level(sat, val, w_red);
        pixel.green = channel_level(sat, val, w_green);
        pixel.blue  = channel_level(sat, val, w_blue);
        return pixel;
    endfunction

    // Offers one item and returns just after the clock edge that takes it.
    // The stall is sampled at the falling edge, where every input has settled,
    // so the decision never races the edge that completes the handshake.
    task automatic send_pixel(input logic [HUE_W-1:0] hue, input chan_t sat, input chan_t val);
        logic taken;
        in_valid    <= 1'b1;
        hue_degrees <= hue;
        saturation  <= sat;
        brightness  <= val;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end while (!taken);
        expected_pixels = {expected_pixels, rgb_from_hsv(hue, sat, val)};
    endtask

    // Drops valid for a number of cycles. The idle payload is scrambled so
    // that the converter is seen to ignore it.
    task automatic idle_sender(input int cycles);
        if (cycles > 0)
        begin
            in_valid    <= 1'b0;
            hue_degrees <= HUE_W'($urandom);
            saturation  <= chan_t'($urandom);
            brightness  <= chan_t'($urandom);
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Levels lean toward the ends of the range, where the arithmetic is tightest.
    function automatic chan_t random_level();
        case ($urandom_range(0, 7))
            0: return chan_t'(0);
            1: return chan_t'(LEVEL_MAX);
            default: return chan_t'($urandom_range(0, LEVEL_MAX));
        endcase
    endfunction

    // Both ends of every field, all ones and all zeros on the hue.
    task automatic test_field_extremes();
        send_pixel(10'd0, 8'd0, 8'd0);
        send_pixel(10'd0, 8'd255, 8'd255);
        send_pixel(10'd1023, 8'd255, 8'd255);
        send_pixel(10'd1023, 8'd0, 8'd0);
        send_pixel(10'd359, 8'd255, 8'd1);
        send_pixel(10'd360, 8'd1, 8'd255);
        idle_sender($urandom_range(1, 4));
    endtask

    // The middle of each sector, so every placement of chroma and secondary is seen.
    task automatic test_sector_centers();
        send_pixel(10'd30, 8'd255, 8'd255);
        send_pixel(10'd90, 8'd200, 8'd180);
        send_pixel(10'd150, 8'd255, 8'd255);
        send_pixel(10'd210, 8'd200, 8'd180);
        send_pixel(10'd270, 8'd255, 8'd255);
        send_pixel(10'd330, 8'd200, 8'd180);
        idle_sender($urandom_range(1, 4));
    endtask

    // Sector borders and hues past a full turn, which must wrap.
    task automatic test_sector_edges_and_wrap();
        send_pixel(10'd59, 8'd255, 8'd200);
        send_pixel(10'd60, 8'd255, 8'd200);
        send_pixel(10'd119, 8'd255, 8'd200);
        send_pixel(10'd120, 8'd255, 8'd200);
        send_pixel(10'd240, 8'd255, 8'd200);
        send_pixel(10'd359, 8'd255, 8'd200);
        send_pixel(10'd360, 8'd255, 8'd200);
        send_pixel(10'd719, 8'd255, 8'd200);
        send_pixel(10'd720, 8'd255, 8'd200);
        idle_sender($urandom_range(1, 4));
    endtask

    // With no saturation all three channels collapse to the brightness.
    task automatic test_zero_saturation();
        send_pixel(10'd123, 8'd0, 8'd77);
        send_pixel(10'd1000, 8'd0, 8'd255);
        idle_sender($urandom_range(1, 4));
    endtask

    // Random pixels in bursts; about a quarter of the bursts run back to back
    // with no gap, so full-rate streaming is covered as well.
    task automatic test_random_pixels();
        int sent;
        int burst;
        sent = 0;
        while (sent < RANDOM_PIXELS)
        begin
            burst = $urandom_range(1, 24);
            repeat (burst)
            begin
                send_pixel(HUE_W'($urandom_range(0, 1023)), random_level(), random_level());
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
            begin
                idle_sender($urandom_range(1, 10));
            end
        end
        idle_sender(1);
    endtask

    // Waits for every owed pixel, then lets the pipeline run empty a while
    // longer so that any stray extra result is caught.
    task automatic wait_for_drain();
        while (expected_pixels.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Receiver stall pattern: a behavior is drawn afresh for each window of cycles,
    // from never stalling through heavy random stalls to a fixed cadence.
    always @(posedge clk)
    begin
        if (stall_window == 0)
        begin
            stall_mode   = stall_mode_e'($urandom_range(0, 3));
            stall_window = $urandom_range(8, 64);
        end
        stall_window--;
        stall_phase = (stall_phase + 1) % 3;
        case (stall_mode)
            STALL_NONE:        out_stall <= 1'b0;
            STALL_LIGHT:       out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:       out_stall <= ($urandom_range(0, 3) != 0);
            STALL_EVERY_THIRD: out_stall <= (stall_phase == 0);
            default:           out_stall <= 1'b0;
        endcase
    end

    // Result checker and hang watchdog. Both handshakes are judged at the
    // falling edge: what holds there is what the next rising edge accepts.
    always @(negedge clk)
    begin
        rgb_pixel_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_pixels.size() == 0)
            begin
                $error("pixel (%0d, %0d, %0d) arrived with none outstanding", red, green, blue);
                mismatch_count++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (red !== want.red)
                begin
                    $error("red: expected %0d, got %0d", want.red, red);
                    mismatch_count++;
                end
                if (green !== want.green)
                begin
                    $error("green: expected %0d, got %0d", want.green, green);
                    mismatch_count++;
                end
                if (blue !== want.blue)
                begin
                    $error("blue: expected %0d, got %0d", want.blue, blue);
                    mismatch_count++;
                end
            end
        end
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= HANG_LIMIT)
        begin
            $error("no item accepted for %0d cycles, %0d pixels outstanding",
                   HANG_LIMIT, expected_pixels.size());
            $display("simulation failed");
            $finish;
        end
    end

    // Reset once, then the directed checks, then the random stream, then drain and report.
    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        hue_degrees = '0;
        saturation  = '0;
        brightness  = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_extremes();
        test_sector_centers();
        test_sector_edges_and_wrap();
        test_zero_saturation();
        test_random_pixels();
        wait_for_drain();

        if (mismatch_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
